>>> rtl/cartridge_header_decoder_core_defines.svh
// assertion macros shared by the cartridge header decoder rtl
`ifndef CARTRIDGE_HEADER_DECODER_CORE_DEFINES_SVH
`define CARTRIDGE_HEADER_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define CHD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cartridge header decoder: same-cycle check failed");
// antecedent implies consequent in the next cycle
`define CHD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cartridge header decoder: next-cycle check failed");
`else
`define CHD_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CHD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> rtl/chd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chd_pkg;

   // header positions, relative to image address 0x134
   localparam logic [4:0] OFS_COLOR   = 5'd15;
   localparam logic [4:0] OFS_SUPER   = 5'd18;
   localparam logic [4:0] OFS_TYPE    = 5'd19;
   localparam logic [4:0] OFS_ROM     = 5'd20;
   localparam logic [4:0] OFS_RAM     = 5'd21;
   localparam logic [4:0] OFS_VERSION = 5'd24;
   localparam logic [4:0] OFS_END     = 5'd26;

   // mapper class codes
   localparam logic [2:0] CLASS_NONE        = 3'd0;
   localparam logic [2:0] CLASS_MBC1        = 3'd1;
   localparam logic [2:0] CLASS_MBC1_MULTI  = 3'd2;
   localparam logic [2:0] CLASS_MBC2        = 3'd3;
   localparam logic [2:0] CLASS_MBC3        = 3'd4;
   localparam logic [2:0] CLASS_MBC5        = 3'd5;
   localparam logic [2:0] CLASS_UNSUPPORTED = 3'd6;

   // special type and flag codes
   localparam logic [7:0] TYPE_NONE      = 8'h00;
   localparam logic [7:0] TYPE_MBC1      = 8'h01;
   localparam logic [7:0] TYPE_MBC1_ALT  = 8'hEA;
   localparam logic [7:0] TYPE_CLOCK_LO  = 8'h0F;
   localparam logic [7:0] TYPE_CLOCK_HI  = 8'h10;
   localparam logic [7:0] TYPE_RUMBLE_LO = 8'h1C;
   localparam logic [7:0] TYPE_RUMBLE_HI = 8'h1E;
   localparam logic [7:0] COLOR_COMPAT   = 8'h80;
   localparam logic [7:0] COLOR_ONLY     = 8'hC0;
   localparam logic [7:0] SUPER_ENABLE   = 8'h03;
   localparam logic [7:0] CHECK_BIAS     = 8'd25;

   // ram size codes
   localparam logic [7:0] RAM_CODE_NONE = 8'h00;
   localparam logic [7:0] RAM_CODE_2K   = 8'h01;
   localparam logic [7:0] RAM_CODE_8K   = 8'h02;
   localparam logic [7:0] RAM_CODE_128K = 8'h04;

   // bank geometry
   localparam int unsigned BANK_SHIFT       = 14;
   localparam logic [9:0]  ROM_BANKS_MULTI  = 10'd64;
   localparam logic [9:0]  ROM_BANKS_RESET  = 10'd2;

   typedef struct packed {
      logic [4:0] header_offset;
      logic [7:0] header_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [2:0] mapper_class;
      logic       has_battery;
      logic       has_clock;
      logic       has_rumble;
      logic       color_supported;
      logic       super_supported;
      logic [4:0] ram_banks;
      logic [9:0] rom_banks;
      logic       header_valid;
      logic [7:0] rom_size_code;
      logic [7:0] ram_size_code;
      logic [7:0] version_number;
   } rsp_type;

   // mapper class from an effective type code
   function automatic logic [2:0] class_of(input logic [7:0] t);
      logic [2:0] c;
      case (t)
         8'h00, 8'h08, 8'h09:                      c = CLASS_NONE;
         8'h01, 8'h02, 8'h03, 8'hEA, 8'hFF:        c = CLASS_MBC1;
         8'h05, 8'h06:                             c = CLASS_MBC2;
         8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'hFC: c = CLASS_MBC3;
         8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E: c = CLASS_MBC5;
         default:                                  c = CLASS_UNSUPPORTED;
      endcase
      return c;
   endfunction

   // battery-backed type codes
   function automatic logic battery_of(input logic [7:0] t);
      logic b;
      case (t)
         8'h03, 8'h06, 8'h09, 8'h0D, 8'h0F, 8'h10, 8'h13,
         8'h17, 8'h1B, 8'h1E, 8'h22, 8'hFD, 8'hFF: b = 1'b1;
         default:                                  b = 1'b0;
      endcase
      return b;
   endfunction

   // power-of-two ceiling of a 16 KiB bank count, clamped to 2..512
   function automatic logic [9:0] bank_ceil(input logic [9:0] n);
      logic [9:0] p;
      p = 10'd512;
      for (int k = 8; k >= 1; k--) begin
         if (n <= (10'd1 << k)) begin
            p = 10'd1 << k;
         end
      end
      return p;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cartridge_header_decoder_core.sv
// rsp holds a result in the cycle after its last-marked byte; rate is one header
// byte per cycle while req_ready is high, set by the single sum and capture stage
// a byte is taken while a result waits, as long as the result register drains
// reset (synchronous, active high) clears the sum and captured bytes, empties
// the result register and sets the image size to 32 KiB (two rom banks)
`timescale 1ns / 1ps
`default_nettype none
`include "cartridge_header_decoder_core_defines.svh"

module cartridge_header_decoder_core
   import chd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_payload,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [23:0] csr_data
);

   logic [7:0] sum_ff,     sum_in;
   logic [7:0] color_ff,   color_in;
   logic [7:0] super_ff,   super_in;
   logic [7:0] type_ff,    type_in;
   logic [7:0] rom_ff,     rom_in;
   logic [7:0] ram_ff,     ram_in;
   logic [7:0] version_ff, version_in;
   logic [9:0] rom_banks_ff, rom_banks_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       req_fire;
   logic       in_range;
   logic [7:0] eff_type;
   logic [2:0] base_class;
   logic [4:0] ram_banks;
   logic [7:0] check_sum;

   // handshakes
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // bank count follows the image size, worked out when it is written
   always_comb begin
      rom_banks_in = rom_banks_ff;
      if (csr_valid) begin
         rom_banks_in = bank_ceil(csr_data[23:BANK_SHIFT]);
      end
   end

   // running sum and byte captures, including the byte now transferred
   always_comb begin
      in_range   = req_payload.header_offset < OFS_END;
      sum_in     = sum_ff;
      color_in   = color_ff;
      super_in   = super_ff;
      type_in    = type_ff;
      rom_in     = rom_ff;
      ram_in     = ram_ff;
      version_in = version_ff;
      if (req_fire && in_range) begin
         sum_in = sum_ff + req_payload.header_byte;
         case (req_payload.header_offset)
            OFS_COLOR:   color_in   = req_payload.header_byte;
            OFS_SUPER:   super_in   = req_payload.header_byte;
            OFS_TYPE:    type_in    = req_payload.header_byte;
            OFS_ROM:     rom_in     = req_payload.header_byte;
            OFS_RAM:     ram_in     = req_payload.header_byte;
            OFS_VERSION: version_in = req_payload.header_byte;
            default:     ;
         endcase
      end
   end

   // decode of the completed header
   always_comb begin
      eff_type = type_in;
      if (type_in != TYPE_MBC1_ALT && rom_in == 8'h00) begin
         eff_type = TYPE_NONE;
      end
      base_class = class_of(eff_type);

      case (ram_in)
         RAM_CODE_NONE: ram_banks = (base_class == CLASS_MBC2) ? 5'd1 : 5'd0;
         RAM_CODE_2K:   ram_banks = 5'd1;
         RAM_CODE_8K:   ram_banks = 5'd1;
         RAM_CODE_128K: ram_banks = 5'd16;
         default:       ram_banks = 5'd4;
      endcase

      check_sum = sum_in + CHECK_BIAS;

      rsp_data_in.mapper_class    = base_class;
      if (base_class == CLASS_MBC1 && type_in == TYPE_MBC1 && ram_in == RAM_CODE_NONE &&
          rom_banks_ff == ROM_BANKS_MULTI) begin
         rsp_data_in.mapper_class = CLASS_MBC1_MULTI;
      end
      rsp_data_in.has_battery     = battery_of(eff_type);
      rsp_data_in.has_clock       = (eff_type == TYPE_CLOCK_LO) || (eff_type == TYPE_CLOCK_HI);
      rsp_data_in.has_rumble      = (eff_type >= TYPE_RUMBLE_LO) &&
                                    (eff_type <= TYPE_RUMBLE_HI);
      rsp_data_in.color_supported = (color_in == COLOR_COMPAT) || (color_in == COLOR_ONLY);
      rsp_data_in.super_supported = (super_in == SUPER_ENABLE);
      rsp_data_in.ram_banks       = ram_banks;
      rsp_data_in.rom_banks       = rom_banks_ff;
      rsp_data_in.header_valid    = (check_sum == 8'h00);
      rsp_data_in.rom_size_code   = rom_in;
      rsp_data_in.ram_size_code   = ram_in;
      rsp_data_in.version_number  = version_in;
   end

   // result register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire && req_payload.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and header state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         color_ff     <= '0;
         super_ff     <= '0;
         type_ff      <= '0;
         rom_ff       <= '0;
         ram_ff       <= '0;
         version_ff   <= '0;
         rom_banks_ff <= ROM_BANKS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rom_banks_ff <= rom_banks_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire && req_payload.last) begin
            sum_ff     <= '0;
            color_ff   <= '0;
            super_ff   <= '0;
            type_ff    <= '0;
            rom_ff     <= '0;
            ram_ff     <= '0;
            version_ff <= '0;
         end else begin
            sum_ff     <= sum_in;
            color_ff   <= color_in;
            super_ff   <= super_in;
            type_ff    <= type_in;
            rom_ff     <= rom_in;
            ram_ff     <= ram_in;
            version_ff <= version_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_fire && req_payload.last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // checks
   `CHD_ASSERT_NEXT(a_last_gives_result, clock, reset, req_fire && req_payload.last, rsp_valid_ff)
   `CHD_ASSERT_NEXT(a_last_clears_sum, clock, reset, req_fire && req_payload.last, sum_ff == 8'h00)
   `CHD_ASSERT_SAME(a_stall_only_when_full, clock, reset, !req_ready, rsp_valid_ff && !rsp_ready)
   `CHD_ASSERT_SAME(a_banks_pow2, clock, reset, 1'b1, $onehot(rom_banks_ff) && !rom_banks_ff[0])
   `CHD_ASSERT_SAME(a_result_from_last, clock, reset, $rose(rsp_valid_ff), $past(req_fire && req_payload.last))

endmodule

`default_nettype wire

>>> tb/sv/cartridge_header_decoder_core_tb.sv
`timescale 1ns / 1ps

module cartridge_header_decoder_core_tb;
   import chd_pkg::*;

   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned MAX_ROM_BANKS = 512;
   localparam logic [4:0]  OFS_CHECKSUM  = 5'd25;
   localparam int unsigned PHASE_BYTES   = 75;
   localparam int unsigned PHASE_HEADERS = 7;

   // type codes drawn for random headers, every decoded case plus some neighbors
   localparam int unsigned NUM_TYPES = 26;
   localparam logic [NUM_TYPES*8-1:0] KNOWN_TYPES = {
      8'h00, 8'h01, 8'h02, 8'h03, 8'h05, 8'h06, 8'h08, 8'h09, 8'h0D, 8'h0F,
      8'h10, 8'h11, 8'h12, 8'h13, 8'h17, 8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D,
      8'h1E, 8'h22, 8'hEA, 8'hFC, 8'hFD, 8'hFF
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [23:0] csr_data    = '0;

   // transfers seen at the last rising edge
   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;
   bit csr_fire = 1'b0;

   req_type     pending_bytes[$];
   rsp_type     expected_decodes[$];
   int unsigned bytes_queued   = 0;
   int unsigned headers_queued = 0;
   int unsigned results_seen   = 0;
   int unsigned idle_cycles    = 0;
   int unsigned error_count    = 0;

   // shadow of the header decoder state
   logic [23:0] rom_total_cfg = 24'd32768;
   logic [7:0]  hdr_sum       = '0;
   logic [7:0]  color_byte    = '0;
   logic [7:0]  super_byte    = '0;
   logic [7:0]  type_code     = '0;
   logic [7:0]  rom_code      = '0;
   logic [7:0]  ram_code      = '0;
   logic [7:0]  version_code  = '0;

   int unsigned send_gap  = 0;
   int unsigned send_calm = 0;
   int unsigned sink_gap  = 0;
   int unsigned sink_calm = 0;
   int unsigned hold_left = 0;

   cartridge_header_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #10 clock = ~clock;

   // mapper class of an effective type code
   function automatic logic [2:0] mapper_for_type(input logic [7:0] t);
      case (t)
         8'h00, 8'h08, 8'h09:                      return CLASS_NONE;
         8'h01, 8'h02, 8'h03, 8'hEA, 8'hFF:        return CLASS_MBC1;
         8'h05, 8'h06:                             return CLASS_MBC2;
         8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'hFC: return CLASS_MBC3;
         8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E: return CLASS_MBC5;
         default:                                  return CLASS_UNSUPPORTED;
      endcase
   endfunction

   function automatic logic battery_for_type(input logic [7:0] t);
      case (t)
         8'h03, 8'h06, 8'h09, 8'h0D, 8'h0F, 8'h10, 8'h13,
         8'h17, 8'h1B, 8'h1E, 8'h22, 8'hFD, 8'hFF: return 1'b1;
         default:                                  return 1'b0;
      endcase
   endfunction

   // decode of the header bytes gathered so far
   function automatic rsp_type decode_header();
      rsp_type     d;
      logic [7:0]  eff;
      logic [7:0]  chk;
      int unsigned n;
      int unsigned p;
      d = '0;
      eff = (type_code != TYPE_MBC1_ALT && rom_code == 8'h00) ? TYPE_NONE : type_code;
      d.mapper_class    = mapper_for_type(eff);
      d.has_battery     = battery_for_type(eff);
      d.has_clock       = (eff == TYPE_CLOCK_LO || eff == TYPE_CLOCK_HI);
      d.has_rumble      = (eff >= TYPE_RUMBLE_LO && eff <= TYPE_RUMBLE_HI);
      d.color_supported = (color_byte == COLOR_COMPAT || color_byte == COLOR_ONLY);
      d.super_supported = (super_byte == SUPER_ENABLE);
      case (ram_code)
         RAM_CODE_NONE:            d.ram_banks = (d.mapper_class == CLASS_MBC2) ? 5'd1 : 5'd0;
         RAM_CODE_2K, RAM_CODE_8K: d.ram_banks = 5'd1;
         RAM_CODE_128K:            d.ram_banks = 5'd16;
         default:                  d.ram_banks = 5'd4;
      endcase
      // power-of-two ceiling of 16 KiB banks, clamped
      n = 32'(rom_total_cfg >> BANK_SHIFT);
      if (n <= 2) begin
         p = 2;
      end else begin
         p = 1;
         while (p < n) p = p << 1;
         if (p > MAX_ROM_BANKS) p = MAX_ROM_BANKS;
      end
      d.rom_banks = p[9:0];
      if (d.mapper_class == CLASS_MBC1 && type_code == TYPE_MBC1 &&
          ram_code == RAM_CODE_NONE && d.rom_banks == ROM_BANKS_MULTI) begin
         d.mapper_class = CLASS_MBC1_MULTI;
      end
      chk = hdr_sum + CHECK_BIAS;
      d.header_valid   = (chk == 8'h00);
      d.rom_size_code  = rom_code;
      d.ram_size_code  = ram_code;
      d.version_number = version_code;
      return d;
   endfunction

   // fold one accepted byte into the shadow state
   task automatic absorb_byte(input req_type r);
      if (r.header_offset < OFS_END) begin
         hdr_sum = hdr_sum + r.header_byte;
         case (r.header_offset)
            OFS_COLOR:   color_byte   = r.header_byte;
            OFS_SUPER:   super_byte   = r.header_byte;
            OFS_TYPE:    type_code    = r.header_byte;
            OFS_ROM:     rom_code     = r.header_byte;
            OFS_RAM:     ram_code     = r.header_byte;
            OFS_VERSION: version_code = r.header_byte;
            default: ;
         endcase
      end
      if (r.last) begin
         expected_decodes.push_back(decode_header());
         hdr_sum      = '0;
         color_byte   = '0;
         super_byte   = '0;
         type_code    = '0;
         rom_code     = '0;
         ram_code     = '0;
         version_code = '0;
      end
   endtask

   task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic compare_decode(input rsp_type want, input rsp_type got);
      check_field("mapper_class", 10'(want.mapper_class), 10'(got.mapper_class));
      check_field("has_battery", 10'(want.has_battery), 10'(got.has_battery));
      check_field("has_clock", 10'(want.has_clock), 10'(got.has_clock));
      check_field("has_rumble", 10'(want.has_rumble), 10'(got.has_rumble));
      check_field("color_supported", 10'(want.color_supported), 10'(got.color_supported));
      check_field("super_supported", 10'(want.super_supported), 10'(got.super_supported));
      check_field("ram_banks", 10'(want.ram_banks), 10'(got.ram_banks));
      check_field("rom_banks", want.rom_banks, got.rom_banks);
      check_field("header_valid", 10'(want.header_valid), 10'(got.header_valid));
      check_field("rom_size_code", 10'(want.rom_size_code), 10'(got.rom_size_code));
      check_field("ram_size_code", 10'(want.ram_size_code), 10'(got.ram_size_code));
      check_field("version_number", 10'(want.version_number), 10'(got.version_number));
   endtask

   // idle length: mostly none or short, a few long, now and then a calm run
   function automatic int unsigned draw_gap(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // monitor: sample transfers, update the shadow and check results
   always @(posedge clock) begin
      req_fire = !reset && req_valid && req_ready;
      rsp_fire = !reset && rsp_valid && rsp_ready;
      csr_fire = !reset && csr_valid && csr_ready;
      if (rsp_fire) begin
         results_seen++;
         if (expected_decodes.size() == 0) begin
            $error("result transfer with no decode expected");
            error_count++;
         end else begin
            compare_decode(expected_decodes.pop_front(), rsp_payload);
         end
      end
      if (req_fire) absorb_byte(req_payload);
      if (csr_fire) rom_total_cfg = csr_data;
      if (!reset) begin
         if (req_fire || rsp_fire || csr_fire) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   // driver: one header byte at a time from the pending queue
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // hold until the transfer
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap--;
      end else if (pending_bytes.size() > 0) begin
         req_payload <= pending_bytes.pop_front();
         req_valid   <= 1'b1;
         send_gap = draw_gap(send_calm);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result sink: random stalls, and a long hold-off every 25 results
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (rsp_fire && results_seen % 25 == 0) begin
         rsp_ready <= 1'b0;
         hold_left = $urandom_range(150, 300);
      end else if (sink_gap > 0) begin
         rsp_ready <= 1'b0;
         sink_gap--;
      end else begin
         rsp_ready <= 1'b1;
         sink_gap = draw_gap(sink_calm);
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("simulation failed");
      $finish;
   end

   task automatic send_byte(input logic [4:0] ofs, input logic [7:0] b, input logic lst);
      req_type r;
      r.header_offset = ofs;
      r.header_byte   = b;
      r.last          = lst;
      pending_bytes.push_back(r);
      bytes_queued++;
      if (lst) headers_queued++;
   endtask

   task automatic send_multi_candidate();
      send_byte(OFS_TYPE, TYPE_MBC1, 1'b0);
      send_byte(OFS_ROM, 8'h05, 1'b0);
      send_byte(OFS_RAM, RAM_CODE_NONE, 1'b1);
   endtask

   // well-formed header with random content, either whole or key bytes only;
   // some whole ones are cut short
   task automatic send_random_header(input bit whole);
      logic [7:0]  img [26];
      logic [7:0]  s;
      logic [4:0]  picks[$];
      int unsigned k;
      for (int i = 0; i < 26; i++) img[i] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) begin
         k = $urandom_range(0, NUM_TYPES - 1);
         img[OFS_TYPE] = KNOWN_TYPES[k*8 +: 8];
      end
      case ($urandom_range(0, 4))
         0:       img[OFS_ROM] = 8'h00;
         1:       ;
         default: img[OFS_ROM] = 8'($urandom_range(0, 8));
      endcase
      if ($urandom_range(0, 4) != 0) img[OFS_RAM] = 8'($urandom_range(0, 5));
      case ($urandom_range(0, 2))
         0:       img[OFS_COLOR] = COLOR_COMPAT;
         1:       img[OFS_COLOR] = COLOR_ONLY;
         default: ;
      endcase
      if ($urandom_range(0, 1) != 0) img[OFS_SUPER] = SUPER_ENABLE;
      if (whole) begin
         for (int i = 0; i < 26; i++) picks.push_back(5'(i));
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 20)) void'(picks.pop_back());
         end
      end else begin
         picks = '{OFS_COLOR, OFS_SUPER, OFS_TYPE, OFS_ROM, OFS_RAM, OFS_VERSION, OFS_CHECKSUM};
      end
      // fix the checksum byte half of the time
      if ($urandom_range(0, 1) != 0) begin
         s = CHECK_BIAS;
         foreach (picks[i]) if (picks[i] != OFS_CHECKSUM) s = s + img[picks[i]];
         img[OFS_CHECKSUM] = 8'h00 - s;
      end
      foreach (picks[i]) send_byte(picks[i], img[picks[i]], i == picks.size() - 1);
   endtask

   // stray bytes at any offset with random last marks
   task automatic send_noise();
      repeat ($urandom_range(1, 6)) begin
         send_byte(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                   $urandom_range(0, 2) == 0);
      end
   endtask

   task automatic send_random_phase();
      int unsigned byte_base;
      int unsigned header_base;
      int unsigned r;
      byte_base   = bytes_queued;
      header_base = headers_queued;
      while (bytes_queued - byte_base < PHASE_BYTES ||
             headers_queued - header_base < PHASE_HEADERS) begin
         r = $urandom_range(0, 9);
         if (r < 4) send_random_header(1'b1);
         else if (r < 8) send_random_header(1'b0);
         else send_noise();
      end
   endtask

   // wait until every byte is taken and every decode has come back
   task automatic wait_drained();
      do @(posedge clock); while (pending_bytes.size() != 0 || req_valid);
      do @(negedge clock); while (expected_decodes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_rom_size(input logic [23:0] v);
      @(negedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [23:0] sizes [8];
      logic [7:0]  fix;
      sizes[0] = 24'd0;
      sizes[1] = 24'd1048576;
      sizes[2] = 24'hFFFFFF;
      sizes[3] = 24'd540672;
      sizes[4] = 24'd8388608;
      sizes[5] = 24'd49152;
      sizes[6] = 24'($urandom_range(0, 8388608));
      sizes[7] = 24'd1064959;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // alternate mbc1 type survives a zero rom size code
      send_byte(OFS_TYPE, TYPE_MBC1_ALT, 1'b0);
      send_byte(OFS_ROM, 8'h00, 1'b0);
      send_byte(OFS_RAM, RAM_CODE_NONE, 1'b1);
      // zero rom size code forces type none
      send_byte(OFS_TYPE, 8'h03, 1'b0);
      send_byte(OFS_ROM, 8'h00, 1'b1);
      // repeated offset, latest capture wins, checksum fixed up
      fix = 8'h00 - (COLOR_COMPAT + COLOR_ONLY + SUPER_ENABLE + 8'hFF + CHECK_BIAS);
      send_byte(OFS_COLOR, COLOR_COMPAT, 1'b0);
      send_byte(OFS_COLOR, COLOR_ONLY, 1'b0);
      send_byte(OFS_SUPER, SUPER_ENABLE, 1'b0);
      send_byte(OFS_VERSION, 8'hFF, 1'b0);
      send_byte(5'd0, fix, 1'b1);
      // byte past the header is dropped but its last mark still counts
      send_byte(5'd31, 8'hFF, 1'b1);
      // rumble with battery, 128 KiB ram code
      send_byte(OFS_TYPE, TYPE_RUMBLE_HI, 1'b0);
      send_byte(OFS_ROM, 8'hFF, 1'b0);
      send_byte(OFS_RAM, RAM_CODE_128K, 1'b1);
      send_byte(OFS_TYPE, TYPE_CLOCK_LO, 1'b0);
      send_byte(OFS_ROM, 8'h01, 1'b0);
      send_byte(OFS_RAM, 8'hFF, 1'b1);
      // mbc2 has its own ram with code zero
      send_byte(OFS_TYPE, 8'h06, 1'b0);
      send_byte(OFS_ROM, 8'h02, 1'b0);
      send_byte(OFS_RAM, RAM_CODE_NONE, 1'b0);
      send_byte(OFS_CHECKSUM, 8'h00, 1'b1);
      send_byte(5'd0, 8'h00, 1'b1);
      send_byte(OFS_TYPE, TYPE_CLOCK_HI, 1'b0);
      send_byte(OFS_ROM, 8'h02, 1'b0);
      send_byte(OFS_RAM, RAM_CODE_2K, 1'b1);
      send_random_phase();

      // one phase per image size, each opening with a multi candidate
      for (int i = 0; i < 8; i++) begin
         wait_drained();
         write_rom_size(sizes[i]);
         send_multi_candidate();
         send_random_phase();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_decodes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
